// ===== rtl/fmp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_pkg: shared types and constants for the frame mse / psnr meter
// frame record passed from the sample accumulator to the result engine
// ----------------------------------------------------------------------------
package fmp_pkg;

  localparam int unsigned MaxFrameSamples = 8388608;
  localparam int unsigned MaxFrames       = 1048576;

  localparam logic [23:0] PeakSqQ8     = 24'd16646400;
  localparam logic [14:0] PsnrCapQ8    = 15'd25600;
  localparam logic [33:0] TenLog10Two  = 34'd12929139865;
  localparam logic [39:0] SumMax       = 40'hFF_FFFF_FFFF;
  localparam logic [44:0] MseTotalMax  = {45{1'b1}};
  localparam logic [35:0] PsnrTotalMax = {36{1'b1}};

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef logic [FifoAw-1:0] fifo_ptr_t;
  typedef logic [FifoAw:0]   fifo_cnt_t;

  localparam fifo_cnt_t FifoFull = fifo_cnt_t'(FifoDepth);

  typedef struct packed {
    logic [39:0] sum;
    logic [23:0] count;
  } frame_rec_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MSE_DIV, ST_LOG_NORM, ST_LOG_SQ, ST_LOG_MUL, ST_PSNR,
    ST_ACC, ST_AVG_M, ST_LOAD_P, ST_AVG_P, ST_OUT
  } eng_state_t;

endpackage

// ===== rtl/fmp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_front: sample accumulator
// squares sample differences, counts samples and queues one record per frame
// ----------------------------------------------------------------------------
module fmp_front
  import fmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ref_sample,
  input  logic [7:0]  test_sample,
  input  logic        last_in_frame,
  output logic        rec_valid,
  input  logic        rec_ready,
  output frame_rec_t  rec_data
);

  logic [23:0] cnt_r;
  logic [39:0] sum_r;
  fifo_ptr_t   wp_r, rp_r;
  fifo_cnt_t   fill_r;
  frame_rec_t  q_r [FifoDepth];

  logic        take, pop, room;
  logic [7:0]  d;
  logic [15:0] sq;
  logic [40:0] sum_add;
  logic [39:0] sum_new;
  logic [23:0] cnt_new;

  assign room     = (fill_r != FifoFull);
  assign in_ready = room;
  assign take     = in_valid && in_ready;
  assign rec_valid = (fill_r != '0);
  assign pop       = rec_valid && rec_ready;
  assign rec_data  = q_r[rp_r];

  always_comb begin
    d   = (ref_sample >= test_sample) ? ref_sample - test_sample : test_sample - ref_sample;
    sq  = d * d;
    sum_add = {1'b0, sum_r} + {25'd0, sq};
    if (cnt_r < 24'(MaxFrameSamples)) begin
      sum_new = sum_add[40] ? SumMax : sum_add[39:0];
      cnt_new = cnt_r + 24'd1;
    end else begin
      sum_new = sum_r;
      cnt_new = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
    end else begin
      if (take) begin
        if (last_in_frame) begin
          cnt_r <= '0;
          sum_r <= '0;
          wp_r  <= wp_r + fifo_ptr_t'(1);
        end else begin
          cnt_r <= cnt_new;
          sum_r <= sum_new;
        end
      end
      if (pop) rp_r <= rp_r + fifo_ptr_t'(1);
      fill_r <= fill_r + fifo_cnt_t'(take && last_in_frame) - fifo_cnt_t'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_in_frame) begin
      q_r[wp_r] <= '{sum: sum_new, count: cnt_new};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= FifoFull)
    else $error("queue overfill");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 24'(MaxFrameSamples))
    else $error("sample count past limit");
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && last_in_frame) |=> (cnt_r == '0))
    else $error("frame not cleared");

endmodule

// ===== rtl/fmp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmp_back: result engine
// serial divides and a squaring log2 unit form mse, psnr and averages
// ----------------------------------------------------------------------------
module fmp_back
  import fmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rec_valid,
  output logic        rec_ready,
  input  frame_rec_t  rec_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] frame_number,
  output logic [23:0] frame_mse,
  output logic [14:0] frame_psnr,
  output logic [23:0] average_mse,
  output logic [14:0] average_psnr
);

  eng_state_t  st_r, st_nxt;
  logic [5:0]  it_r;
  // shared restoring divider, one quotient bit per cycle
  logic [48:0] quo_r;
  logic [23:0] rem_r;
  logic [24:0] den_r;
  logic [24:0] shl;
  logic [25:0] trial;
  // log2 unit, first pass on the peak, second on the frame mse
  logic        pass_r;
  logic [31:0] y_r;
  logic [4:0]  k_r;
  logic [23:0] frac_r;
  logic [28:0] top_r;
  logic [62:0] prod_r;
  logic [63:0] ysq;
  logic [32:0] ynext;
  logic [23:0] frac_nxt;
  logic [23:0] log_x;
  logic [4:0]  lead;
  logic [28:0] bot, dlt;
  logic [63:0] prod_rnd;
  logic [15:0] pr;
  logic [23:0] m_clamp;

  logic [23:0] m_r;
  logic [14:0] p_r;
  logic [20:0] fd_r;
  logic [44:0] mt_r;
  logic [35:0] pt_r;
  logic [23:0] am_r;

  logic [20:0] fd_nxt;
  logic [44:0] mt_nxt;
  logic [35:0] pt_nxt;
  logic [45:0] mt_add;
  logic [36:0] pt_add;

  assign shl      = {rem_r, quo_r[48]};
  assign trial    = {1'b0, shl} - {1'b0, den_r};
  assign ysq      = 64'(y_r) * 64'(y_r);
  assign ynext    = ysq[62:30];
  assign frac_nxt = {frac_r[22:0], ynext[31]};
  assign log_x    = pass_r ? m_r : PeakSqQ8;
  assign bot      = {k_r, frac_r};
  assign dlt      = (top_r > bot) ? top_r - bot : '0;
  assign prod_rnd = {1'b0, prod_r} + (64'd1 << 47);
  assign pr       = prod_rnd[63:48];
  assign m_clamp  = (quo_r > 49'(PeakSqQ8)) ? PeakSqQ8 : quo_r[23:0];
  assign mt_add   = {1'b0, mt_r} + 46'(m_r);
  assign pt_add   = {1'b0, pt_r} + 37'(p_r);

  assign rec_ready = (st_r == ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
  assign frame_number = fd_r;
  assign frame_mse    = m_r;
  assign frame_psnr   = p_r;
  assign average_mse  = am_r;
  assign average_psnr = quo_r[14:0];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 24; i++) begin
      if (log_x[i]) lead = 5'(i);
    end
  end

  always_comb begin
    if (fd_r < 21'(MaxFrames)) begin
      fd_nxt = fd_r + 21'd1;
      mt_nxt = mt_add[45] ? MseTotalMax : mt_add[44:0];
      pt_nxt = pt_add[36] ? PsnrTotalMax : pt_add[35:0];
    end else begin
      fd_nxt = fd_r;
      mt_nxt = mt_r;
      pt_nxt = pt_r;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:     if (rec_valid) st_nxt = ST_MSE_DIV;
      ST_MSE_DIV:  if (it_r == 6'd0) st_nxt = ST_LOG_NORM;
      ST_LOG_NORM: st_nxt = (!pass_r && m_clamp == 24'd0) ? ST_ACC : ST_LOG_SQ;
      ST_LOG_SQ:   if (it_r == 6'd0) st_nxt = pass_r ? ST_LOG_MUL : ST_LOG_NORM;
      ST_LOG_MUL:  st_nxt = ST_PSNR;
      ST_PSNR:     st_nxt = ST_ACC;
      ST_ACC:      st_nxt = ST_AVG_M;
      ST_AVG_M:    if (it_r == 6'd0) st_nxt = ST_LOAD_P;
      ST_LOAD_P:   st_nxt = ST_AVG_P;
      ST_AVG_P:    if (it_r == 6'd0) st_nxt = ST_OUT;
      ST_OUT:      if (out_ready) st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      fd_r <= '0;
      mt_r <= '0;
      pt_r <= '0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        ST_IDLE: begin
          if (rec_valid) begin
            quo_r  <= 49'({rec_data.sum, 8'd0}) + 49'(rec_data.count >> 1);
            rem_r  <= '0;
            den_r  <= 25'(rec_data.count);
            it_r   <= 6'd48;
            pass_r <= 1'b0;
          end
        end
        ST_MSE_DIV, ST_AVG_M, ST_AVG_P: begin
          rem_r <= trial[25] ? shl[23:0] : trial[23:0];
          quo_r <= {quo_r[47:0], ~trial[25]};
          if (it_r != 6'd0) it_r <= it_r - 6'd1;
        end
        ST_LOG_NORM: begin
          if (!pass_r) m_r <= m_clamp;
          if (!pass_r && m_clamp == 24'd0) p_r <= PsnrCapQ8;
          k_r    <= lead;
          y_r    <= 32'(log_x) << (5'd30 - lead);
          frac_r <= '0;
          it_r   <= 6'd23;
        end
        ST_LOG_SQ: begin
          y_r    <= ynext[31] ? ynext[32:1] : ynext[31:0];
          frac_r <= frac_nxt;
          if (it_r != 6'd0) it_r <= it_r - 6'd1;
          if (it_r == 6'd0 && !pass_r) begin
            top_r  <= {k_r, frac_nxt};
            pass_r <= 1'b1;
          end
        end
        ST_LOG_MUL: prod_r <= 63'(dlt) * 63'(TenLog10Two);
        ST_PSNR:    p_r <= (pr > 16'(PsnrCapQ8)) ? PsnrCapQ8 : pr[14:0];
        ST_ACC: begin
          fd_r  <= fd_nxt;
          mt_r  <= mt_nxt;
          pt_r  <= pt_nxt;
          quo_r <= 49'(mt_nxt) + 49'(fd_nxt >> 1);
          rem_r <= '0;
          den_r <= 25'(fd_nxt);
          it_r  <= 6'd48;
        end
        ST_LOAD_P: begin
          am_r  <= quo_r[23:0];
          quo_r <= 49'(pt_r) + 49'(fd_r >> 1);
          rem_r <= '0;
          it_r  <= 6'd48;
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (p_r <= PsnrCapQ8))
    else $error("psnr above cap");
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (m_r <= PeakSqQ8))
    else $error("mse above peak");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(fd_r))
    else $error("result lost");

endmodule

// ===== rtl/frame_mse_psnr_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_mse_psnr_meter: per-frame mse and psnr of 8-bit sample pairs
//
// in_ stream: one sample pair per item, tlast marks the last item of a frame.
// samples are taken one per cycle while the frame queue has room.
// out_ stream: one result item per frame. out_tvalid rises once the frame
// has passed the serial 49-step divider (used three times) and the 24-step
// squaring log2 unit (run twice, skipped when the mse rounds to zero); the
// engine takes no new frame until the result item is taken. up to four closed
// frames queue in front of the result engine; input stalls only when that
// queue is full.
// reset clears sums, counts, frame totals and the queue.
// a stalled receiver holds the result item, the engine waits.
// ----------------------------------------------------------------------------
module frame_mse_psnr_meter
  import fmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // ref_sample, test_sample
  input  logic        in_tlast,   // last_in_frame
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [103:0] out_tdata  // frame_number, frame_mse, frame_psnr, average_mse, average_psnr
);

  logic       rec_valid, rec_ready;
  frame_rec_t rec_data;
  logic [20:0] fn;
  logic [23:0] fm, am;
  logic [14:0] fp, ap;

  fmp_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .ref_sample(in_tdata[7:0]), .test_sample(in_tdata[15:8]),
    .last_in_frame(in_tlast), .rec_valid, .rec_ready, .rec_data
  );

  fmp_back u_back (
    .clk, .rst_n, .rec_valid, .rec_ready, .rec_data,
    .out_valid(out_tvalid), .out_ready(out_tready),
    .frame_number(fn), .frame_mse(fm), .frame_psnr(fp),
    .average_mse(am), .average_psnr(ap)
  );

  assign out_tdata = {5'd0, ap, am, fp, fm, fn};

endmodule
